### rtl/olt_pkg.sv
`default_nettype none

package olt_pkg;

	localparam int CMD_W    = 2;
	localparam int CLIENT_W = 4;
	localparam int THREAD_W = 16;
	localparam int LOCK_W   = 6;
	localparam int COUNT_W  = 16;

	localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ACQUIRE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

	localparam logic STAT_OK   = 1'b0;
	localparam logic STAT_BUSY = 1'b1;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef struct packed {
		logic lock_we;
		logic cnt_we;
	} olt_we_t;

endpackage

`default_nettype wire

### rtl/owned_lock_table_unit.sv
// Owned lock table.
// Input channel (in_valid/in_stall): command, client_id, thread_id, lock_index.
// Output channel (out_valid/out_stall): status, acquire_count; one result per
// transfer in, in request order.
// Acquire takes a free lock (bumps the client's per-lock count, saturating),
// is a no-op for the current owner, and answers busy otherwise. Release frees
// the lock for its owner only. Query returns the client's count for that lock.
// Path: lookup stage (registered RAM read), then the result register.
// Throughput: one request per cycle unless stalled; lock state and counts
// live in two single-port-write RAMs read with same-cycle write forwarding,
// so back-to-back requests to the same lock see the previous update.
// Reset: a clearing pass walks the count RAM (and the lock RAM alongside),
// one entry per cycle, NUM_CLIENTS*NUM_LOCKS entries (1024 by default);
// in_stall stays high until it finishes.
// When out_stall is high the result register holds; one more request is
// taken into the lookup stage, then in_stall rises until the result drains.
`default_nettype none

module owned_lock_table_unit import olt_pkg::*; #(
	parameter int NUM_LOCKS   = 64,
	parameter int NUM_CLIENTS = 16,
	parameter int THREAD_BITS = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [CMD_W-1:0]    command,
	input  wire logic [CLIENT_W-1:0] client_id,
	input  wire logic [THREAD_W-1:0] thread_id,
	input  wire logic [LOCK_W-1:0]   lock_index,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic                     status,
	output logic [COUNT_W-1:0]       acquire_count
);

	localparam int TW        = (THREAD_BITS < THREAD_W) ? THREAD_BITS : THREAD_W;
	localparam int LW        = 1 + CLIENT_W + TW;
	localparam int CNT_DEPTH = NUM_CLIENTS * NUM_LOCKS;
	localparam int LA_W      = $clog2(NUM_LOCKS);
	localparam int CA_W      = $clog2(CNT_DEPTH);

	logic            clr_busy_q;
	logic [CA_W-1:0] clr_addr_q;
	logic            in_fire;
	logic            hold;
	olt_we_t         core_we;

	logic [LA_W-1:0]    lock_addr;
	logic [CA_W-1:0]    cnt_addr;
	logic [LA_W-1:0]    core_lock_waddr;
	logic [LW-1:0]      core_lock_wdata;
	logic [CA_W-1:0]    core_cnt_waddr;
	logic [COUNT_W-1:0] core_cnt_wdata;

	logic               lock_we;
	logic [LA_W-1:0]    lock_waddr;
	logic [LW-1:0]      lock_wdata;
	logic               cnt_we;
	logic [CA_W-1:0]    cnt_waddr;
	logic [COUNT_W-1:0] cnt_wdata;
	logic [LW-1:0]      lock_rd;
	logic [COUNT_W-1:0] cnt_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + CA_W'(1);
			if (clr_addr_q == CA_W'(CNT_DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	assign in_stall = clr_busy_q || hold;
	assign in_fire  = in_valid && !in_stall;

	assign lock_addr = LA_W'(lock_index);
	assign cnt_addr  = CA_W'(32'(client_id) * 32'(NUM_LOCKS) + 32'(lock_index));

	assign lock_we    = clr_busy_q ? (clr_addr_q < CA_W'(NUM_LOCKS)) : core_we.lock_we;
	assign lock_waddr = clr_busy_q ? LA_W'(clr_addr_q) : core_lock_waddr;
	assign lock_wdata = clr_busy_q ? '0 : core_lock_wdata;
	assign cnt_we     = clr_busy_q || core_we.cnt_we;
	assign cnt_waddr  = clr_busy_q ? clr_addr_q : core_cnt_waddr;
	assign cnt_wdata  = clr_busy_q ? '0 : core_cnt_wdata;

	olt_ram #(
		.DEPTH (NUM_LOCKS),
		.WIDTH (LW),
		.AW    (LA_W)
	) u_lock_ram (
		.clk   (clk),
		.we    (lock_we),
		.waddr (lock_waddr),
		.wdata (lock_wdata),
		.re    (in_fire),
		.raddr (lock_addr),
		.rdata (lock_rd)
	);

	olt_ram #(
		.DEPTH (CNT_DEPTH),
		.WIDTH (COUNT_W),
		.AW    (CA_W)
	) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.re    (in_fire),
		.raddr (cnt_addr),
		.rdata (cnt_rd)
	);

	olt_core #(
		.NUM_LOCKS   (NUM_LOCKS),
		.NUM_CLIENTS (NUM_CLIENTS),
		.TW          (TW),
		.LA_W        (LA_W),
		.CA_W        (CA_W),
		.LW          (LW)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_fire       (in_fire),
		.command       (command),
		.client_id     (client_id),
		.thread_in     (thread_id[TW-1:0]),
		.lock_index    (lock_index),
		.lock_addr     (lock_addr),
		.cnt_addr      (cnt_addr),
		.lock_rd       (lock_rd),
		.cnt_rd        (cnt_rd),
		.out_stall     (out_stall),
		.hold          (hold),
		.we            (core_we),
		.lock_waddr    (core_lock_waddr),
		.lock_wdata    (core_lock_wdata),
		.cnt_waddr     (core_cnt_waddr),
		.cnt_wdata     (core_cnt_wdata),
		.out_valid     (out_valid),
		.status        (status),
		.acquire_count (acquire_count)
	);

	a_clear_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> (in_stall && !core_we.lock_we && !core_we.cnt_we))
		else $error("request activity during clearing pass");

endmodule

`default_nettype wire

### rtl/olt_ram.sv
`default_nettype none

module olt_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 8,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// same-cycle write to the read address is forwarded
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= (we && waddr == raddr) ? wdata : mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### rtl/olt_core.sv
`default_nettype none

module olt_core import olt_pkg::*; #(
	parameter int NUM_LOCKS   = 64,
	parameter int NUM_CLIENTS = 16,
	parameter int TW          = 16,
	parameter int LA_W        = 6,
	parameter int CA_W        = 10,
	parameter int LW          = 1 + CLIENT_W + TW
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_fire,
	input  wire logic [CMD_W-1:0]    command,
	input  wire logic [CLIENT_W-1:0] client_id,
	input  wire logic [TW-1:0]       thread_in,
	input  wire logic [LOCK_W-1:0]   lock_index,
	input  wire logic [LA_W-1:0]     lock_addr,
	input  wire logic [CA_W-1:0]     cnt_addr,
	input  wire logic [LW-1:0]       lock_rd,
	input  wire logic [COUNT_W-1:0]  cnt_rd,
	input  wire logic                out_stall,
	output logic                     hold,
	output olt_we_t                  we,
	output logic [LA_W-1:0]          lock_waddr,
	output logic [LW-1:0]            lock_wdata,
	output logic [CA_W-1:0]          cnt_waddr,
	output logic [COUNT_W-1:0]       cnt_wdata,
	output logic                     out_valid,
	output logic                     status,
	output logic [COUNT_W-1:0]       acquire_count
);

	logic                valid_s1;
	logic [CMD_W-1:0]    cmd_s1;
	logic [CLIENT_W-1:0] client_s1;
	logic [TW-1:0]       thread_s1;
	logic                range_s1;
	logic [LA_W-1:0]     laddr_s1;
	logic [CA_W-1:0]     caddr_s1;

	logic                out_valid_q;
	logic                status_q;
	logic [COUNT_W-1:0]  count_q;

	logic                advance;
	logic                in_range;
	logic                held;
	logic [CLIENT_W-1:0] own_client;
	logic [TW-1:0]       own_thread;
	logic                is_owner;
	logic                lock_set;
	logic                lock_clr;
	logic                busy;
	logic [COUNT_W-1:0]  cnt_res;

	assign in_range = (32'(lock_index) < NUM_LOCKS) && (32'(client_id) < NUM_CLIENTS);

	assign advance = valid_s1 && (!out_valid_q || !out_stall);
	assign hold    = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_s1    <= command;
			client_s1 <= client_id;
			thread_s1 <= thread_in;
			range_s1  <= in_range;
			laddr_s1  <= lock_addr;
			caddr_s1  <= cnt_addr;
		end
	end

	assign held       = lock_rd[LW-1];
	assign own_client = lock_rd[TW +: CLIENT_W];
	assign own_thread = lock_rd[TW-1:0];
	assign is_owner   = held && own_client == client_s1 && own_thread == thread_s1;

	always_comb begin
		lock_set = 1'b0;
		lock_clr = 1'b0;
		busy     = STAT_OK;
		cnt_res  = '0;
		if (range_s1) begin
			case (cmd_s1)
				CMD_QUERY: begin
					cnt_res = cnt_rd;
				end
				CMD_ACQUIRE: begin
					if (!is_owner) begin
						if (held) begin
							busy = STAT_BUSY;
						end else begin
							lock_set = 1'b1;
						end
					end
				end
				CMD_RELEASE: begin
					lock_clr = is_owner;
				end
				default: begin
				end
			endcase
		end
	end

	assign lock_wdata = lock_set ? {1'b1, client_s1, thread_s1} : {1'b0, own_client, own_thread};
	assign cnt_wdata  = (cnt_rd == COUNT_MAX) ? cnt_rd : cnt_rd + COUNT_W'(1);
	assign lock_waddr = laddr_s1;
	assign cnt_waddr  = caddr_s1;
	assign we.lock_we = advance && (lock_set || lock_clr);
	assign we.cnt_we  = advance && lock_set;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q <= busy;
			count_q  <= cnt_res;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign acquire_count = count_q;

	a_cnt_with_take: assert property (@(posedge clk) disable iff (!arst_n)
		we.cnt_we |-> (we.lock_we && lock_wdata[LW-1]))
		else $error("count written without taking the lock");

	a_query_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && cmd_s1 == CMD_QUERY) |-> (!we.lock_we && !we.cnt_we))
		else $error("query wrote state");

	a_busy_acquire: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && busy == STAT_BUSY) |-> (cmd_s1 == CMD_ACQUIRE && held && !is_owner))
		else $error("busy without a foreign holder");

endmodule

`default_nettype wire

### bench/owned_lock_table_unit_tb.sv
`default_nettype none

module owned_lock_table_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import olt_pkg::*;

	localparam int NUM_LOCKS   = 64;
	localparam int NUM_CLIENTS = 16;
	localparam int RUN_LIMIT   = 1_000_000;
	localparam int POOL_SIZE   = 6;
	localparam int PHASE_ITEMS = 240;
	localparam int SAT_PAIRS   = 10;

	localparam logic [CMD_W-1:0]    CMD_UNUSED = 2'd3;
	localparam logic [LOCK_W-1:0]   SAT_LOCK   = 6'd37;
	localparam logic [CLIENT_W-1:0] SAT_CLIENT = 4'd9;
	localparam logic [THREAD_W-1:0] SAT_THREAD = 16'hA5A5;

	typedef struct packed {
		logic               st;
		logic [COUNT_W-1:0] cnt;
	} reply_t;

	typedef struct {
		logic [CMD_W-1:0]    cmd;
		logic [CLIENT_W-1:0] cl;
		logic [THREAD_W-1:0] th;
		logic [LOCK_W-1:0]   lk;
		bit                  typed;
		reply_t              want;
	} req_row_t;

	logic                clk           = 1'b0;
	logic                arst_n        = 1'b0;
	logic                in_valid      = 1'b0;
	logic                out_stall     = 1'b0;
	logic [CMD_W-1:0]    command       = CMD_QUERY;
	logic [CLIENT_W-1:0] client_id     = '0;
	logic [THREAD_W-1:0] thread_id     = '0;
	logic [LOCK_W-1:0]   lock_index    = '0;
	logic                in_stall;
	logic                out_valid;
	logic                status;
	logic [COUNT_W-1:0]  acquire_count;

	owned_lock_table_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.client_id    (client_id),
		.thread_id    (thread_id),
		.lock_index   (lock_index),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.acquire_count(acquire_count)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// shadow lock table
	bit                  lock_busy[NUM_LOCKS];
	logic [CLIENT_W-1:0] holder_cl[NUM_LOCKS];
	logic [THREAD_W-1:0] holder_th[NUM_LOCKS];
	logic [COUNT_W-1:0]  take_tally[NUM_CLIENTS][NUM_LOCKS];

	reply_t              pending_replies[$];
	int                  errors    = 0;
	int                  cycles    = 0;
	int                  idle_den  = 0;
	int                  stall_den = 0;
	int                  stall_left = 0;

	logic [LOCK_W-1:0]   hot_locks[4];
	logic [CLIENT_W-1:0] pool_cl[POOL_SIZE];
	logic [THREAD_W-1:0] pool_th[POOL_SIZE];

	req_row_t directed[24] = '{
		'{CMD_QUERY,   4'd0,  16'h0000, 6'd0,  1'b1, '{STAT_OK,   16'd0}},
		'{CMD_QUERY,   4'd15, 16'hFFFF, 6'd63, 1'b1, '{STAT_OK,   16'd0}},
		'{CMD_RELEASE, 4'd0,  16'h0000, 6'd0,  1'b1, '{STAT_OK,   16'd0}},
		'{CMD_ACQUIRE, 4'd0,  16'h0000, 6'd0,  1'b1, '{STAT_OK,   16'd0}},
		'{CMD_ACQUIRE, 4'd0,  16'h0000, 6'd0,  1'b1, '{STAT_OK,   16'd0}},
		'{CMD_ACQUIRE, 4'd0,  16'h0001, 6'd0,  1'b1, '{STAT_BUSY, 16'd0}},
		'{CMD_ACQUIRE, 4'd1,  16'h0000, 6'd0,  1'b1, '{STAT_BUSY, 16'd0}},
		'{CMD_RELEASE, 4'd1,  16'h0000, 6'd0,  1'b1, '{STAT_OK,   16'd0}},
		'{CMD_ACQUIRE, 4'd1,  16'h0000, 6'd0,  1'b1, '{STAT_BUSY, 16'd0}},
		'{CMD_QUERY,   4'd0,  16'h1234, 6'd0,  1'b1, '{STAT_OK,   16'd1}},
		'{CMD_QUERY,   4'd1,  16'h0000, 6'd0,  1'b1, '{STAT_OK,   16'd0}},
		'{CMD_RELEASE, 4'd0,  16'h0000, 6'd0,  1'b1, '{STAT_OK,   16'd0}},
		'{CMD_ACQUIRE, 4'd1,  16'h0000, 6'd0,  1'b1, '{STAT_OK,   16'd0}},
		'{CMD_QUERY,   4'd1,  16'h0000, 6'd0,  1'b1, '{STAT_OK,   16'd1}},
		'{CMD_UNUSED,  4'd1,  16'h0000, 6'd0,  1'b1, '{STAT_OK,   16'd0}},
		'{CMD_ACQUIRE, 4'd15, 16'hFFFF, 6'd63, 1'b1, '{STAT_OK,   16'd0}},
		'{CMD_ACQUIRE, 4'd15, 16'hFFFE, 6'd63, 1'b1, '{STAT_BUSY, 16'd0}},
		'{CMD_UNUSED,  4'd15, 16'hFFFF, 6'd63, 1'b1, '{STAT_OK,   16'd0}},
		'{CMD_RELEASE, 4'd15, 16'hFFFF, 6'd63, 1'b1, '{STAT_OK,   16'd0}},
		'{CMD_ACQUIRE, 4'd14, 16'hFFFF, 6'd63, 1'b1, '{STAT_OK,   16'd0}},
		'{CMD_QUERY,   4'd15, 16'h0000, 6'd63, 1'b1, '{STAT_OK,   16'd1}},
		'{CMD_RELEASE, 4'd14, 16'hFFFF, 6'd63, 1'b0, '{STAT_OK,   16'd0}},
		'{CMD_RELEASE, 4'd1,  16'h0000, 6'd0,  1'b0, '{STAT_OK,   16'd0}},
		'{CMD_QUERY,   4'd1,  16'hFFFF, 6'd0,  1'b0, '{STAT_OK,   16'd0}}
	};

	function automatic reply_t lock_table_step(input logic [CMD_W-1:0] cmd,
			input logic [CLIENT_W-1:0] cl, input logic [THREAD_W-1:0] th,
			input logic [LOCK_W-1:0] lk);
		reply_t r;
		bit     mine;
		r = '{st: STAT_OK, cnt: '0};
		if (lk < NUM_LOCKS && cl < NUM_CLIENTS) begin
			mine = lock_busy[lk] && holder_cl[lk] == cl && holder_th[lk] == th;
			case (cmd)
				CMD_QUERY: begin
					r.cnt = take_tally[cl][lk];
				end
				CMD_ACQUIRE: begin
					if (!mine) begin
						if (lock_busy[lk]) begin
							r.st = STAT_BUSY;
						end else begin
							lock_busy[lk] = 1'b1;
							holder_cl[lk] = cl;
							holder_th[lk] = th;
							if (take_tally[cl][lk] != COUNT_MAX)
								take_tally[cl][lk] = take_tally[cl][lk] + COUNT_W'(1);
						end
					end
				end
				CMD_RELEASE: begin
					if (mine)
						lock_busy[lk] = 1'b0;
				end
				default: ;
			endcase
		end
		return r;
	endfunction

	function automatic req_row_t make_row(input logic [CMD_W-1:0] cmd,
			input logic [CLIENT_W-1:0] cl, input logic [THREAD_W-1:0] th,
			input logic [LOCK_W-1:0] lk);
		req_row_t r;
		r.cmd   = cmd;
		r.cl    = cl;
		r.th    = th;
		r.lk    = lk;
		r.typed = 1'b0;
		r.want  = '{st: STAT_OK, cnt: '0};
		return r;
	endfunction

	task automatic note_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (errors < 40)
			$display("tb: mismatch %s: got %0h, want %0h", what, got, want);
		errors++;
	endtask

	task automatic send_req(input req_row_t r);
		reply_t p;
		if (idle_den != 0 && $urandom_range(0, idle_den - 1) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		command    <= r.cmd;
		client_id  <= r.cl;
		thread_id  <= r.th;
		lock_index <= r.lk;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		p = lock_table_step(r.cmd, r.cl, r.th, r.lk);
		pending_replies.push_back(r.typed ? r.want : p);
	endtask

	// mostly contention on a few hot locks by a small set of owners, rest is noise
	task automatic send_random();
		req_row_t r;
		int       k;
		int       pick;
		r = make_row(CMD_W'($urandom_range(0, 3)), CLIENT_W'($urandom()),
			THREAD_W'($urandom()), LOCK_W'($urandom()));
		if ($urandom_range(0, 9) < 7) begin
			k    = $urandom_range(0, POOL_SIZE - 1);
			r.lk = hot_locks[$urandom_range(0, 3)];
			r.cl = pool_cl[k];
			r.th = pool_th[k];
			if (lock_busy[r.lk] && $urandom_range(0, 1) == 1) begin
				r.cl  = holder_cl[r.lk];
				r.th  = holder_th[r.lk];
				r.cmd = ($urandom_range(0, 3) == 0) ? CMD_ACQUIRE : CMD_RELEASE;
			end else begin
				pick = $urandom_range(0, 5);
				r.cmd = (pick == 0) ? CMD_QUERY : (pick < 4) ? CMD_ACQUIRE : CMD_RELEASE;
			end
		end
		send_req(r);
	endtask

	always @(posedge clk) begin
		cycles++;
		if (cycles > RUN_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	always @(posedge clk) begin
		reply_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_replies.size() == 0) begin
				note_mismatch("unexpected transfer", 32'({status, acquire_count}), '0);
			end else begin
				w = pending_replies.pop_front();
				if (status !== w.st)
					note_mismatch("status", 32'(status), 32'(w.st));
				if (acquire_count !== w.cnt)
					note_mismatch("acquire_count", 32'(acquire_count), 32'(w.cnt));
			end
		end
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (stall_den != 0 && $urandom_range(0, stall_den - 1) == 0) begin
			stall_left = $urandom_range(0, 13);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	initial begin
		req_row_t r;
		foreach (lock_busy[i])
			lock_busy[i] = 1'b0;
		foreach (take_tally[c, l])
			take_tally[c][l] = '0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		idle_den  = 3;
		stall_den = 5;
		foreach (directed[i])
			send_req(directed[i]);

		for (int ph = 0; ph < 5; ph++) begin
			case (ph % 3)
				0: begin
					idle_den  = 4;
					stall_den = 6;
				end
				1: begin
					idle_den  = 0;
					stall_den = 0;
				end
				default: begin
					idle_den  = 2;
					stall_den = 2;
				end
			endcase
			foreach (hot_locks[i])
				hot_locks[i] = LOCK_W'($urandom());
			if (ph == 0)
				hot_locks[0] = '1;
			foreach (pool_cl[i]) begin
				pool_cl[i] = CLIENT_W'($urandom());
				pool_th[i] = THREAD_W'($urandom());
			end
			// two threads of one client contend
			pool_cl[1] = pool_cl[0];
			pool_th[POOL_SIZE-1] = '1;
			repeat (PHASE_ITEMS) send_random();
		end

		// repeated take and release of one lock, no idling from here on
		idle_den  = 0;
		stall_den = 0;
		if (lock_busy[SAT_LOCK])
			send_req(make_row(CMD_RELEASE, holder_cl[SAT_LOCK], holder_th[SAT_LOCK],
				SAT_LOCK));
		repeat (SAT_PAIRS) begin
			send_req(make_row(CMD_ACQUIRE, SAT_CLIENT, SAT_THREAD, SAT_LOCK));
			send_req(make_row(CMD_RELEASE, SAT_CLIENT, SAT_THREAD, SAT_LOCK));
		end
		send_req(make_row(CMD_ACQUIRE, SAT_CLIENT, SAT_THREAD, SAT_LOCK));
		r = make_row(CMD_ACQUIRE, SAT_CLIENT + 1'b1, SAT_THREAD, SAT_LOCK);
		r.typed   = 1'b1;
		r.want.st = STAT_BUSY;
		send_req(r);
		send_req(make_row(CMD_QUERY, SAT_CLIENT, SAT_THREAD, SAT_LOCK));
		send_req(make_row(CMD_RELEASE, SAT_CLIENT, SAT_THREAD, SAT_LOCK));
		send_req(make_row(CMD_QUERY, SAT_CLIENT, 16'h0000, SAT_LOCK));
		in_valid <= 1'b0;

		while (pending_replies.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire

### sim.f
rtl/olt_pkg.sv
rtl/olt_ram.sv
rtl/olt_core.sv
rtl/owned_lock_table_unit.sv
bench/owned_lock_table_unit_tb.sv
